[rtl/core/sma_crossover_trader_core_macros.svh]
// Assertion macros for the crossover trader
`ifndef SMA_CROSSOVER_TRADER_CORE_MACROS_SVH
`define SMA_CROSSOVER_TRADER_CORE_MACROS_SVH
// implication checked on every clock, muted in reset
`define SCT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define SCT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[rtl/core/sct_pkg.sv]
// Types, constants and helpers shared by the crossover trader modules
`default_nettype none
package sct_pkg;
    localparam int WinDepth = 32;
    localparam int WinBits = $clog2(WinDepth);
    localparam int CntBits = $clog2(WinDepth + 1);
    localparam int SumBits = 40 + WinBits;

    localparam logic [1:0] ACT_HOLD = 2'd0;
    localparam logic [1:0] ACT_BUY  = 2'd1;
    localparam logic [1:0] ACT_SELL = 2'd2;

    localparam logic [1:0] REG_SHORT = 2'd0;
    localparam logic [1:0] REG_LONG  = 2'd1;
    localparam logic [1:0] REG_CASH  = 2'd2;

    localparam logic [47:0] CASH_RESET = 48'd655360000;
    localparam logic [5:0]  SHORT_RESET = 6'd5;
    localparam logic [5:0]  LONG_RESET  = 6'd20;

    typedef struct packed {
        logic [39:0] close_price;
        logic        last_candle;
    } t_in;

    typedef struct packed {
        logic [1:0]         action;
        logic [55:0]        cash_now;
        logic [47:0]        shares_held;
        logic signed [55:0] equity_gain;
        logic signed [55:0] realized_gain;
        logic [15:0]        trade_count;
    } t_out;

    // request handed from front to back through the queue
    typedef struct packed {
        logic [39:0] price;
        logic        last;
        logic        tested;
        logic        bull;
    } t_req;

    function automatic logic [CntBits-1:0] clamp_win(input logic [5:0] w);
        logic [CntBits-1:0] r;
        if (w == 6'd0) r = CntBits'(1);
        else if (32'(w) > WinDepth) r = CntBits'(WinDepth);
        else r = CntBits'(w);
        return r;
    endfunction
endpackage
`default_nettype wire

[rtl/core/sma_crossover_trader_core.sv]
// Top level of the moving-average crossover trader
// Usage:
//  Input channel (i_valid/o_stall, i_data) takes one candle per request:
//  close price with 16 fractional bits and a last-candle flag.
//  Output channel (o_valid/i_stall, o_data) returns one result per candle:
//  action, cash, shares, equity gain, realized gain and trade count.
//  Front: the candle goes into a 32-entry ring; the window sums are swept one
//  entry a cycle (skipped during warm-up), the test is registered, then the
//  request goes into a 2-deep queue. The front stalls its input until the
//  request has entered the queue. Back: a hold runs the decision and one serial
//  product for the equity; a sell adds two serial products (48x8 per step),
//  a buy adds a restoring divider (one quotient bit a cycle), and closing out
//  on the last candle adds a sell.
//  Sequential rate is set by the slower of front and back; buys dominate.
//  Reset: synchronous, active low; windows 5 and 20, cash 10000.0.
//  A stalled result is held in the output register; the back waits in turn.
//  APB registers at 8-byte spacing: 0 short_window, 1 long_window, 2 initial_cash.
`default_nettype none
module sma_crossover_trader_core import sct_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire t_in         i_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output t_out             o_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);
    logic [5:0]  r_short, r_long;
    logic        wr;
    logic [1:0]  reg_idx;
    logic [47:0] init_cash;
    logic        req_valid, req_full, q_valid, q_pop;
    t_req        req, q_req;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    assign reg_idx = paddr[4:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short <= SHORT_RESET;
            r_long <= LONG_RESET;
        end else if (wr) begin
            case (reg_idx)
                REG_SHORT: r_short <= pwdata[5:0];
                REG_LONG:  r_long <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SHORT: prdata = 64'(r_short);
            REG_LONG:  prdata = 64'(r_long);
            REG_CASH:  prdata = 64'(init_cash);
            default:   prdata = '0;
        endcase
    end

    sct_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .i_short_window(r_short), .i_long_window(r_long),
        .o_req_valid(req_valid), .i_req_full(req_full), .o_req(req)
    );

    sct_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(req_valid), .i_data(req), .o_full(req_full),
        .o_valid(q_valid), .i_pop(q_pop), .o_data(q_req)
    );

    sct_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(q_valid), .o_req_pop(q_pop), .i_req(q_req),
        .i_cash_wr(wr && reg_idx == REG_CASH), .i_cash_val(pwdata[47:0]),
        .o_init_cash(init_cash),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );
endmodule
`default_nettype wire

[rtl/core/sct_front.sv]
// Front end: close ring, window sums and crossover test
`default_nettype none
module sct_front import sct_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire t_in               i_data,
    input  wire logic [5:0]        i_short_window,
    input  wire logic [5:0]        i_long_window,
    output logic                   o_req_valid,
    input  wire logic              i_req_full,
    output t_req                   o_req
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SUM  = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;
    localparam logic [1:0] S_PUSH = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [39:0]         r_ring [WinDepth];
    logic [WinBits-1:0]  r_head;
    logic [CntBits-1:0]  r_seen;
    logic [CntBits-1:0]  r_idx;
    logic [SumBits-1:0]  r_ssum, r_lsum;
    logic [CntBits-1:0]  r_sw, r_lw;
    logic                r_test;
    logic [39:0]         r_rd;
    t_req                r_req;
    logic [WinBits-1:0]  rd_addr;
    logic [CntBits-1:0]  span;

    assign o_stall = (r_state != S_IDLE);
    assign o_req_valid = (r_state == S_PUSH);
    assign o_req = r_req;
    // r_idx counts ages; the read is registered, so r_rd holds age r_idx-1
    assign rd_addr = r_head - r_idx[WinBits-1:0];
    // sweep must cover the longer of the two windows
    assign span = (r_sw > r_lw) ? r_sw : r_lw;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_SUM;
            S_SUM:  if (!r_test || r_idx == span + CntBits'(1)) n_state = S_MUL;
            S_MUL:  n_state = S_PUSH;
            S_PUSH: if (!i_req_full) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head <= '0;
            r_seen <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && i_valid) begin
                r_head <= r_head + WinBits'(1);
                if (32'(r_seen) < WinDepth) r_seen <= r_seen + CntBits'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_ring[rd_addr];
        if (r_state == S_IDLE && i_valid) begin
            r_ring[r_head + WinBits'(1)] <= i_data.close_price;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_sw <= clamp_win(i_short_window);
                r_lw <= clamp_win(i_long_window);
                r_test <= (r_seen >= clamp_win(i_long_window)) &&
                          ((r_seen + CntBits'(1)) >= clamp_win(i_short_window));
                r_idx <= '0;
                r_ssum <= '0;
                r_lsum <= '0;
                r_req.price <= i_data.close_price;
                r_req.last <= i_data.last_candle;
            end
            S_SUM: begin
                r_idx <= r_idx + CntBits'(1);
                if (r_idx != '0) begin
                    if (r_idx <= r_sw) r_ssum <= r_ssum + SumBits'(r_rd);
                    if (r_idx <= r_lw) r_lsum <= r_lsum + SumBits'(r_rd);
                end
            end
            S_MUL: begin
                // exact compare of the means: short_sum*lw against long_sum*sw
                r_req.tested <= r_test;
                r_req.bull <= ((SumBits+CntBits)'(r_ssum) * (SumBits+CntBits)'(r_lw)) >
                              ((SumBits+CntBits)'(r_lsum) * (SumBits+CntBits)'(r_sw));
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

[rtl/core/sct_queue.sv]
// Two-entry request queue between front and back
`default_nettype none
module sct_queue import sct_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_req i_data,
    output logic      o_full,
    output logic      o_valid,
    input  wire logic i_pop,
    output t_req      o_data
);
    t_req       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) r_wp <= ~r_wp;
            if (i_pop && o_valid) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'((i_push && !o_full) ? 1 : 0)
                           - 2'((i_pop && o_valid) ? 1 : 0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wp] <= i_data;
    end
endmodule
`default_nettype wire

[rtl/core/sct_back.sv]
// Back end: trade decisions, serial divider and multiplier, result register
`default_nettype none
module sct_back import sct_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_req_valid,
    output logic             o_req_pop,
    input  wire t_req        i_req,
    input  wire logic        i_cash_wr,
    input  wire logic [47:0] i_cash_val,
    output logic [47:0]      o_init_cash,
    output logic             o_valid,
    input  wire logic        i_stall,
    output t_out             o_data
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_SELL1 = 4'd3;
    localparam logic [3:0] S_SELL2 = 4'd4;
    localparam logic [3:0] S_LAST  = 4'd5;
    localparam logic [3:0] S_EQ    = 4'd6;
    localparam logic [3:0] S_MULW  = 4'd8;

    localparam logic [63:0] SMAX = 64'h007F_FFFF_FFFF_FFFF;

    logic [3:0]          r_state, n_state;
    logic [3:0]          r_ret;
    logic [55:0]         r_cash;
    logic [47:0]         r_pos;
    logic [39:0]         r_entry;
    logic signed [55:0]  r_real;
    logic [15:0]         r_trades;
    logic                r_prev;
    logic [47:0]         r_init;
    logic [1:0]          r_act;
    t_req                r_req;
    // serial divider
    logic [6:0]          r_k;
    logic [40:0]         r_rem;
    logic [47:0]         r_q;
    logic                r_qsat;
    // serial multiplier: a (48b) x b (40b), 8 bits of b per step
    logic [47:0]         r_ma;
    logic [39:0]         r_mb;
    logic [2:0]          r_mstep;
    logic [87:0]         r_macc;
    logic [63:0]         r_mmax;
    logic [63:0]         r_mres;
    logic                r_neg;
    logic                r_out_v;
    t_out                r_out;

    logic [40:0] rem_sh;
    logic        cash_bit;
    logic [47:0] q_sh;
    logic [55:0] pp8;
    logic [87:0] pp;
    logic [87:0] macc_nx;
    logic [63:0] mul_sat;
    logic [39:0] diff;
    logic signed [57:0] gsum;
    logic signed [57:0] eq;
    logic        out_load;

    assign o_init_cash = r_init;
    assign o_valid = r_out_v;
    assign o_data = r_out;
    assign o_req_pop = (r_state == S_IDLE) && i_req_valid;
    // result register is loaded only once the previous result has left
    assign out_load = (r_state == S_EQ) && (!r_out_v || !i_stall);

    assign cash_bit = (r_k >= 7'd24) ? r_cash[6'(r_k - 7'd24)] : 1'b0;
    assign rem_sh = {r_rem[39:0], cash_bit};
    assign q_sh = {r_q[46:0], 1'b0};
    assign pp8 = 56'(r_ma) * 56'(r_mb[7:0]);
    assign pp = 88'(pp8) << {r_mstep, 3'b000};
    assign macc_nx = r_macc + pp;
    assign diff = (r_req.price >= r_entry) ? r_req.price - r_entry
                                            : r_entry - r_req.price;
    always_comb begin
        if (macc_nx[87:24] > r_mmax) mul_sat = r_mmax;
        else mul_sat = macc_nx[87:24];
    end
    assign gsum = r_neg ? 58'(r_real) - 58'(r_mres) : 58'(r_real) + 58'(r_mres);
    assign eq = 58'(r_cash) + 58'(r_mres) - 58'(r_init);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_req_valid) n_state = S_DEC;
            S_DEC:   n_state = S_LAST;
            S_DIV:   if (r_k == 7'd0) n_state = S_LAST;
            S_MULW:  if (r_mstep == 3'd4) n_state = r_ret;
            S_SELL1: n_state = S_MULW;
            S_SELL2: n_state = S_LAST;
            S_LAST:  n_state = S_MULW;
            S_EQ:    if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_DEC) begin
            if (r_req.tested && !r_prev && r_req.bull && r_pos == '0
                && r_req.price != '0) n_state = S_DIV;
            else if (r_req.tested && r_prev && !r_req.bull && r_pos != '0)
                n_state = S_MULW;
        end
        if (r_state == S_LAST && !(r_req.last && r_pos != '0)) n_state = S_MULW;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cash <= 56'(CASH_RESET);
            r_init <= CASH_RESET;
            r_pos <= '0;
            r_entry <= '0;
            r_real <= '0;
            r_trades <= '0;
            r_prev <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) r_out_v <= 1'b1;
            else if (!i_stall) r_out_v <= 1'b0;
            if (i_cash_wr) begin
                r_init <= i_cash_val;
                if (r_trades == '0 && r_pos == '0) r_cash <= 56'(i_cash_val);
            end
            case (r_state)
                S_IDLE: begin
                    r_req <= i_req;
                    r_act <= ACT_HOLD;
                end
                S_DEC: begin
                    if (r_req.tested) r_prev <= r_req.bull;
                    r_k <= 7'd79;
                    r_rem <= '0;
                    r_q <= '0;
                    r_qsat <= 1'b0;
                    // sell signal: compute cash = pos*price first
                    r_ma <= r_pos;
                    r_mb <= r_req.price;
                    r_mstep <= '0;
                    r_macc <= '0;
                    r_mmax <= {8'd0, 56'hFF_FFFF_FFFF_FFFF};
                    r_ret <= S_SELL1;
                    if (r_req.tested && r_prev && !r_req.bull && r_pos != '0) begin
                        r_act <= ACT_SELL;
                        if (r_trades != 16'hFFFF) r_trades <= r_trades + 16'd1;
                    end
                end
                S_DIV: begin
                    r_k <= r_k - 7'd1;
                    if (rem_sh >= {1'b0, r_req.price}) begin
                        r_rem <= rem_sh - {1'b0, r_req.price};
                        if (r_q[47]) r_qsat <= 1'b1;
                        r_q <= r_q[47] ? '1 : (q_sh | 48'd1);
                    end else begin
                        r_rem <= rem_sh;
                        if (r_q[47]) r_qsat <= 1'b1;
                        r_q <= r_q[47] ? '1 : q_sh;
                    end
                    if (r_k == 7'd0) begin
                        r_pos <= (r_qsat || r_q[47]) ? '1 : (rem_sh >= {1'b0, r_req.price}
                                 ? (q_sh | 48'd1) : q_sh);
                        r_entry <= r_req.price;
                        r_cash <= '0;
                        r_act <= ACT_BUY;
                        if (r_trades != 16'hFFFF) r_trades <= r_trades + 16'd1;
                    end
                end
                S_MULW: begin
                    r_macc <= macc_nx;
                    r_mb <= {8'd0, r_mb[39:8]};
                    r_mstep <= r_mstep + 3'd1;
                    if (r_mstep == 3'd4) r_mres <= mul_sat;
                end
                S_SELL1: begin
                    r_cash <= r_mres[55:0];
                    r_neg <= r_req.price < r_entry;
                    r_ma <= r_pos;
                    r_mb <= diff;
                    r_mstep <= '0;
                    r_macc <= '0;
                    r_mmax <= (r_req.price < r_entry) ? SMAX + 64'd1 : SMAX;
                    r_ret <= S_SELL2;
                end
                S_SELL2: begin
                    if (gsum > 58'sh7F_FFFF_FFFF_FFFF) r_real <= 56'sh7F_FFFF_FFFF_FFFF;
                    else if (gsum < -58'sh80_0000_0000_0000)
                        r_real <= 56'sh80_0000_0000_0000;
                    else r_real <= 56'(gsum);
                    r_pos <= '0;
                end
                S_LAST: begin
                    r_mstep <= '0;
                    r_macc <= '0;
                    r_mb <= r_req.price;
                    r_ma <= r_pos;
                    if (r_req.last && r_pos != '0) begin
                        r_act <= ACT_SELL;
                        r_mmax <= {8'd0, 56'hFF_FFFF_FFFF_FFFF};
                        r_ret <= S_SELL1;
                    end else begin
                        r_mmax <= {8'd0, 56'hFF_FFFF_FFFF_FFFF};
                        r_ret <= S_EQ;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.action <= r_act;
            r_out.cash_now <= r_cash;
            r_out.shares_held <= r_pos;
            r_out.equity_gain <= (eq > 58'sh7F_FFFF_FFFF_FFFF) ? 56'sh7F_FFFF_FFFF_FFFF
                                                                : 56'(eq);
            r_out.realized_gain <= r_real;
            r_out.trade_count <= r_trades;
        end
    end
endmodule
`default_nettype wire

[rtl/core/sct_checker.sv]
// Port-level checker for the crossover trader, bound to the top level
`include "sma_crossover_trader_core_macros.svh"
`default_nettype none
module sct_checker import sct_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_valid,
    input wire logic i_stall,
    input wire t_out o_data,
    input wire logic pready
);
    `SCT_ASSERT_IMP(a_act_code, i_clk, i_rst_n, o_valid, o_data.action != 2'd3)
    `SCT_ASSERT_NXT(a_hold_out, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data))
    `SCT_ASSERT_IMP(a_flat_sell, i_clk, i_rst_n, o_valid && o_data.action == ACT_SELL, o_data.shares_held == '0)
    `SCT_ASSERT_IMP(a_buy_cash, i_clk, i_rst_n, o_valid && o_data.action == ACT_BUY, o_data.cash_now == '0)
    `SCT_ASSERT_IMP(a_ready, i_clk, i_rst_n, 1'b1, pready)
endmodule
bind sma_crossover_trader_core sct_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_stall(i_stall),
    .o_data(o_data), .pready(pready)
);
`default_nettype wire
